@@ rtl/lfdc_pkg.sv @@
`default_nettype none
package lfdc_pkg;

  localparam int unsigned NUM_SENSORS = 8;

  // drive modes
  localparam logic [3:0] MODE_FOLLOW     = 4'd0;
  localparam logic [3:0] MODE_CORNER_IN  = 4'd1;
  localparam logic [3:0] MODE_CORNER_OUT = 4'd2;
  localparam logic [3:0] MODE_RIGHT_DET  = 4'd3;
  localparam logic [3:0] MODE_RIGHT_TURN = 4'd4;
  localparam logic [3:0] MODE_LEFT_DET   = 4'd5;
  localparam logic [3:0] MODE_LEFT_TURN  = 4'd6;
  localparam logic [3:0] MODE_RAMP_UP    = 4'd7;
  localparam logic [3:0] MODE_RAMP_DOWN  = 4'd8;

  // sensor patterns
  localparam logic [2:0] PAT_LEFT   = 3'd0;
  localparam logic [2:0] PAT_RIGHT  = 3'd1;
  localparam logic [2:0] PAT_CORNER = 3'd2;
  localparam logic [2:0] PAT_NOLINE = 3'd3;
  localparam logic [2:0] PAT_ANY    = 3'd4;

  // register indexes
  localparam logic [2:0] CFG_DARK_THRESHOLD  = 3'd0;
  localparam logic [2:0] CFG_DEBOUNCE_COUNT  = 3'd1;
  localparam logic [2:0] CFG_RAMP_UP_PITCH   = 3'd2;
  localparam logic [2:0] CFG_RAMP_DOWN_PITCH = 3'd3;
  localparam logic [2:0] CFG_STRICT_GAIN     = 3'd4;
  localparam logic [2:0] CFG_LOOSE_GAIN      = 3'd5;
  localparam logic [2:0] CFG_FAST_BASE_SPEED = 3'd6;
  localparam logic [2:0] CFG_MEDIUM_SPEED    = 3'd7;

  // ceil(2^37 / 10000), exact floor division for |pitch| < 2^22
  localparam logic [23:0] PITCH_RECIP = 24'd13743896;
  localparam int unsigned PITCH_SHIFT = 37;

  typedef struct packed {
    logic [9:0]  dark_threshold;
    logic [7:0]  debounce_count;
    logic [19:0] ramp_up_pitch;
    logic [19:0] ramp_down_pitch;
    logic [11:0] strict_gain;
    logic [11:0] loose_gain;
    logic [6:0]  fast_base_speed;
    logic [6:0]  medium_speed;
  } cfg_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic [2:0]        pattern;
    logic              ramp_up;     // pitch above ramp up threshold
    logic              pitch_dive;  // pitch below minus ramp down threshold
    logic              below_up;    // pitch below ramp up threshold
    logic              above_down;  // pitch above minus ramp down threshold
    logic signed [8:0] pitch_div;   // pitch / 10000 toward zero
    logic [31:0]       now_ms;
    logic [4:0]        speed_jitter;
  } meta_t;

endpackage
`default_nettype wire

@@ rtl/lfdc_front.sv @@
`default_nettype none
module lfdc_front
  import lfdc_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = 10,
  parameter int unsigned SUM_W       = SENSOR_BITS + 3,
  parameter int unsigned WSUM_W      = SENSOR_BITS + 5
) (
  input  wire logic [NUM_SENSORS*SENSOR_BITS-1:0] sensors_i,
  input  wire logic signed [21:0]                 pitch_urad_i,
  input  wire logic [31:0]                        now_ms_i,
  input  wire logic [4:0]                         speed_jitter_i,
  input  wire cfg_t                               cfg_i,
  output logic [SUM_W-1:0]                        sum_o,
  output logic [WSUM_W-1:0]                       wsum_o,
  output meta_t                                   meta_o
);

  localparam int unsigned CMP_W = (SENSOR_BITS > 10) ? SENSOR_BITS : 10;

  logic [3:0]  dark, ldark, rdark;
  logic [CMP_W-1:0] thr;
  logic [SENSOR_BITS-1:0] s;
  logic [21:0] pmag;
  logic [45:0] pprod;
  logic [8:0]  pq;
  logic signed [22:0] p_ext, up_s, dn_s;

  always_comb begin
    sum_o  = '0;
    wsum_o = '0;
    dark   = '0;
    ldark  = '0;
    rdark  = '0;
    thr    = CMP_W'(cfg_i.dark_threshold);
    for (int i = 0; i < NUM_SENSORS; i++) begin
      s      = sensors_i[i*SENSOR_BITS +: SENSOR_BITS];
      sum_o  = sum_o + SUM_W'(s);
      wsum_o = wsum_o + WSUM_W'(s) * WSUM_W'(i);
      if (CMP_W'(s) < thr) begin
        dark = dark + 4'd1;
        if (i < NUM_SENSORS / 2) ldark = ldark + 4'd1;
        else rdark = rdark + 4'd1;
      end
    end
  end

  always_comb begin
    if (dark > 4'(NUM_SENSORS - 2)) meta_o.pattern = PAT_CORNER;
    else if (ldark > 4'(NUM_SENSORS / 2 - 1)) meta_o.pattern = PAT_LEFT;
    else if (rdark > 4'(NUM_SENSORS / 2 - 1)) meta_o.pattern = PAT_RIGHT;
    else if (dark == 4'd0) meta_o.pattern = PAT_NOLINE;
    else meta_o.pattern = PAT_ANY;
  end

  // pitch thresholds and ramp down drive
  always_comb begin
    p_ext = 23'(pitch_urad_i);
    up_s  = $signed({3'b000, cfg_i.ramp_up_pitch});
    dn_s  = -$signed({3'b000, cfg_i.ramp_down_pitch});
    meta_o.ramp_up    = p_ext > up_s;
    meta_o.pitch_dive = p_ext < dn_s;
    meta_o.below_up   = p_ext < up_s;
    meta_o.above_down = p_ext > dn_s;
    pmag  = pitch_urad_i[21] ? 22'(-p_ext) : 22'(pitch_urad_i);
    pprod = 46'(pmag) * 46'(PITCH_RECIP);
    pq    = pprod[PITCH_SHIFT +: 9];
    meta_o.pitch_div    = pitch_urad_i[21] ? -$signed(pq) : $signed(pq);
    meta_o.now_ms       = now_ms_i;
    meta_o.speed_jitter = speed_jitter_i;
  end

endmodule
`default_nettype wire

@@ rtl/lfdc_fifo.sv @@
`default_nettype none
module lfdc_fifo #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              full_o,
  output logic              empty_o
);

  logic [W-1:0] mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lfdc_back.sv @@
`default_nettype none
module lfdc_back
  import lfdc_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = 10,
  parameter int unsigned SUM_W       = SENSOR_BITS + 3,
  parameter int unsigned WSUM_W      = SENSOR_BITS + 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              empty_i,
  input  wire logic [SUM_W-1:0]  sum_i,
  input  wire logic [WSUM_W-1:0] wsum_i,
  input  wire meta_t             meta_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic signed [9:0]      drive_o,
  output logic signed [14:0]     steering_o,
  output logic [3:0]             drive_mode_o,
  output logic signed [10:0]     line_position_o,
  output logic [2:0]             pattern_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_POS  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       st_q;
  logic [SUM_W-1:0] sum_q, rem_q;
  meta_t            meta_q;
  logic [10:0]      sh_q, q_q;
  logic [3:0]       cnt_q;
  logic             zero_q, neg_q;
  logic signed [10:0] pos_q;
  logic [9:0]       mag_q;
  logic [21:0]      gp_q;
  logic [16:0]      pen_q;

  logic [3:0]  mode_q;
  logic [31:0] entry_q;
  logic [2:0]  prev_q;
  logic [7:0]  rep_q;
  logic signed [14:0] held_q;

  logic [SUM_W:0] trial;
  logic           qbit;
  logic [11:0]    pos_full;
  logic           can_fin;

  assign can_fin = !valid_o || ready_i;
  assign pop_o   = (st_q == ST_IDLE) && !empty_i;
  assign trial   = {rem_q, sh_q[10]};
  assign qbit    = trial >= {1'b0, sum_q};
  assign pos_full = {1'b0, q_q} - 12'd896;

  // sequencer for the finishing cycle
  logic [7:0]  rep_nx;
  logic        conf;
  logic [31:0] el;
  logic [22:0] grnd;
  logic [17:0] prnd;
  logic signed [15:0] steer_g, steer;
  logic signed [10:0] drive;
  logic        has_steer;
  logic [3:0]  next;
  logic signed [9:0]  drive_c;
  logic signed [14:0] steer_c;
  logic [11:0] gain_sel;

  always_comb begin
    case (mode_q)
      MODE_CORNER_IN, MODE_RIGHT_DET, MODE_LEFT_DET: gain_sel = cfg_i.loose_gain;
      default: gain_sel = cfg_i.strict_gain;
    endcase
  end

  always_comb begin
    if (meta_q.pattern == prev_q) rep_nx = (rep_q == 8'hFF) ? rep_q : rep_q + 8'd1;
    else rep_nx = 8'd0;
    conf = rep_nx >= cfg_i.debounce_count;
    el   = meta_q.now_ms - entry_q;
    grnd = {1'b0, gp_q} + 23'd128;
    prnd = {1'b0, pen_q} + 18'd128;
    steer_g = neg_q ? -$signed({1'b0, grnd[22:8]}) : $signed({1'b0, grnd[22:8]});
    steer = 16'(held_q);
    drive = '0;
    has_steer = 1'b1;
    next = mode_q;
    case (mode_q)
      MODE_FOLLOW: begin
        drive = $signed({4'b0, cfg_i.fast_base_speed}) + $signed({6'b0, meta_q.speed_jitter})
                - $signed({1'b0, prnd[17:8]});
        steer = steer_g;
        if (meta_q.ramp_up) next = MODE_RAMP_UP;
        else if (meta_q.pitch_dive) next = MODE_RAMP_DOWN;
        else if (meta_q.pattern == PAT_CORNER && conf) next = MODE_CORNER_IN;
        else if (el > 32'd200 && meta_q.pattern == PAT_RIGHT && conf) next = MODE_RIGHT_DET;
        else if (el > 32'd200 && meta_q.pattern == PAT_LEFT && conf) next = MODE_LEFT_DET;
      end
      MODE_CORNER_IN: begin
        drive = (el < 32'd100) ? -11'sd60 : 11'sd10;
        steer = steer_g;
        if (meta_q.ramp_up) next = MODE_RAMP_UP;
        else if (meta_q.pitch_dive) next = MODE_RAMP_DOWN;
        else if (el > 32'd300 && conf &&
                 (meta_q.pattern == PAT_LEFT || meta_q.pattern == PAT_RIGHT))
          next = MODE_CORNER_OUT;
      end
      MODE_CORNER_OUT: begin
        drive = $signed({4'b0, cfg_i.medium_speed});
        steer = steer_g;
        if (el > 32'd700) next = MODE_FOLLOW;
      end
      MODE_RIGHT_DET, MODE_LEFT_DET: begin
        drive = $signed({4'b0, cfg_i.medium_speed});
        steer = steer_g;
        if (meta_q.pattern == PAT_NOLINE && conf)
          next = (mode_q == MODE_RIGHT_DET) ? MODE_RIGHT_TURN : MODE_LEFT_TURN;
        else if (el > 32'd2500) next = MODE_FOLLOW;
      end
      MODE_RIGHT_TURN, MODE_LEFT_TURN: begin
        drive = $signed({4'b0, cfg_i.medium_speed});
        // right turn swings to negative steering first
        if (el < 32'd650) steer = (mode_q == MODE_RIGHT_TURN) ? -16'sd20 : 16'sd20;
        else if (el < 32'd900) steer = (mode_q == MODE_RIGHT_TURN) ? 16'sd20 : -16'sd20;
        else begin
          has_steer = 1'b0;
          if (meta_q.pattern == PAT_ANY && conf) next = MODE_FOLLOW;
        end
      end
      MODE_RAMP_UP: begin
        drive = 11'sd80;
        steer = steer_g;
        if (meta_q.below_up) next = MODE_FOLLOW;
      end
      MODE_RAMP_DOWN: begin
        drive = 11'(meta_q.pitch_div);
        steer = steer_g;
        if (meta_q.above_down) next = MODE_FOLLOW;
      end
      default: begin
        drive = $signed({4'b0, cfg_i.fast_base_speed});
        steer = steer_g;
        next = MODE_FOLLOW;
      end
    endcase
    if (steer < -16'sd16384) steer_c = -15'sd16384;
    else if (steer > 16'sd16383) steer_c = 15'sd16383;
    else steer_c = steer[14:0];
    if (drive < -11'sd400) drive_c = -10'sd400;
    else if (drive > 11'sd200) drive_c = 10'sd200;
    else drive_c = drive[9:0];
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        sum_q  <= sum_i;
        meta_q <= meta_i;
        rem_q  <= SUM_W'(wsum_i[WSUM_W-1:3]);
        sh_q   <= {wsum_i[2:0], 8'b0};
        zero_q <= sum_i == '0;
      end
      ST_DIV: begin
        rem_q <= qbit ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
        sh_q  <= {sh_q[9:0], 1'b0};
        q_q   <= {q_q[9:0], qbit};
      end
      ST_POS: begin
        pos_q <= zero_q ? 11'sd0 : $signed(pos_full[10:0]);
        neg_q <= !zero_q && pos_full[11];
        mag_q <= zero_q ? 10'd0 : (pos_full[11] ? 10'(-pos_full) : pos_full[9:0]);
      end
      ST_MUL: begin
        gp_q  <= 22'(gain_sel) * 22'(mag_q);
        pen_q <= 17'd100 * 17'(mag_q);
      end
      default: begin
        if (can_fin) begin
          drive_o         <= drive_c;
          steering_o      <= has_steer ? steer_c : held_q;
          drive_mode_o    <= next;
          line_position_o <= pos_q;
          pattern_o       <= meta_q.pattern;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      cnt_q   <= '0;
      valid_o <= 1'b0;
      mode_q  <= MODE_FOLLOW;
      entry_q <= '0;
      prev_q  <= PAT_NOLINE;
      rep_q   <= '0;
      held_q  <= '0;
    end else begin
      if (st_q == ST_FIN && can_fin) valid_o <= 1'b1;
      else if (ready_i) valid_o <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (!empty_i) st_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd10) st_q <= ST_POS;
        end
        ST_POS: st_q <= ST_MUL;
        ST_MUL: st_q <= ST_FIN;
        ST_FIN: begin
          if (can_fin) begin
            if (has_steer) held_q <= steer_c;
            if (next != mode_q) entry_q <= meta_q.now_ms;
            mode_q <= next;
            prev_q <= meta_q.pattern;
            rep_q  <= rep_nx;
            st_q   <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= MODE_RAMP_DOWN) else $error("mode out of range");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV && !zero_q) |-> rem_q < sum_q) else $error("remainder not below divisor");
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_POS && !zero_q) |-> q_q <= 11'd1792) else $error("quotient out of range");
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN && can_fin) |=> valid_o) else $error("result lost");
`endif

endmodule
`default_nettype wire

@@ rtl/line_follow_drive_controller.sv @@
`default_nettype none
// line follow drive controller: each request on the slave stream carries eight line sensor
// readings, the pitch, a millisecond timestamp and a speed jitter, and yields one result with
// the wheel drive, steering, new mode, line position and sensor pattern. the front classifies
// a request in the cycle it is accepted and parks it in a two-entry queue; the back runs an
// 11-step serial divider for the centroid, then the position, gain multiply and mode
// sequencer states in that order, and the sequencer waits while a result is not yet taken.
// the output register lets the next request start while a result still waits. the user must
// write registers through cfg_we_i / cfg_idx_i / cfg_data_i only while no request is in
// flight; the block itself does not enforce this.
module line_follow_drive_controller
  import lfdc_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // fields from lsb: sensor_a..sensor_h, pitch_urad, now_ms, speed_jitter, zero pad
  input  wire logic [((NUM_SENSORS*SENSOR_BITS+59+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic  s_axis_tvalid,
  output logic       s_axis_tready,
  // fields from lsb: drive, steering, drive_mode, line_position, pattern, zero pad
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire logic   m_axis_tready,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i
);

  localparam int unsigned SB     = SENSOR_BITS;
  localparam int unsigned SUM_W  = SB + 3;
  localparam int unsigned WSUM_W = SB + 5;
  localparam int unsigned META_W = $bits(meta_t);
  localparam int unsigned Q_W    = SUM_W + WSUM_W + META_W;

  cfg_t cfg_q;

  // register file, resets to the documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_threshold  <= 10'd500;
      cfg_q.debounce_count  <= 8'd2;
      cfg_q.ramp_up_pitch   <= 20'd9000;
      cfg_q.ramp_down_pitch <= 20'd18000;
      cfg_q.strict_gain     <= 12'd1500;
      cfg_q.loose_gain      <= 12'd25;
      cfg_q.fast_base_speed <= 7'd40;
      cfg_q.medium_speed    <= 7'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DARK_THRESHOLD:  cfg_q.dark_threshold  <= cfg_data_i[9:0];
        CFG_DEBOUNCE_COUNT:  cfg_q.debounce_count  <= cfg_data_i[7:0];
        CFG_RAMP_UP_PITCH:   cfg_q.ramp_up_pitch   <= cfg_data_i;
        CFG_RAMP_DOWN_PITCH: cfg_q.ramp_down_pitch <= cfg_data_i;
        CFG_STRICT_GAIN:     cfg_q.strict_gain     <= cfg_data_i[11:0];
        CFG_LOOSE_GAIN:      cfg_q.loose_gain      <= cfg_data_i[11:0];
        CFG_FAST_BASE_SPEED: cfg_q.fast_base_speed <= cfg_data_i[6:0];
        CFG_MEDIUM_SPEED:    cfg_q.medium_speed    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // front: sums, dark counts, pattern and pitch checks
  logic [SUM_W-1:0]  f_sum;
  logic [WSUM_W-1:0] f_wsum;
  meta_t             f_meta;

  lfdc_front #(.SENSOR_BITS(SB), .SUM_W(SUM_W), .WSUM_W(WSUM_W)) u_front (
    .sensors_i      (s_axis_tdata[NUM_SENSORS*SB-1:0]),
    .pitch_urad_i   ($signed(s_axis_tdata[NUM_SENSORS*SB +: 22])),
    .now_ms_i       (s_axis_tdata[NUM_SENSORS*SB+22 +: 32]),
    .speed_jitter_i (s_axis_tdata[NUM_SENSORS*SB+54 +: 5]),
    .cfg_i          (cfg_q),
    .sum_o          (f_sum),
    .wsum_o         (f_wsum),
    .meta_o         (f_meta)
  );

  // queue between classification and the sequencer
  logic             q_full, q_empty, q_pop;
  logic [Q_W-1:0]   q_data;

  assign s_axis_tready = !q_full;

  lfdc_fifo #(.W(Q_W)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid && !q_full),
    .data_i  ({f_sum, f_wsum, f_meta}),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: centroid divider, gain multiply, mode sequencer, output register
  logic signed [9:0]  drive;
  logic signed [14:0] steering;
  logic [3:0]         drive_mode;
  logic signed [10:0] line_position;
  logic [2:0]         pattern;

  lfdc_back #(.SENSOR_BITS(SB), .SUM_W(SUM_W), .WSUM_W(WSUM_W)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (q_empty),
    .sum_i           (q_data[Q_W-1 -: SUM_W]),
    .wsum_i          (q_data[META_W +: WSUM_W]),
    .meta_i          (q_data[META_W-1:0]),
    .pop_o           (q_pop),
    .valid_o         (m_axis_tvalid),
    .ready_i         (m_axis_tready),
    .drive_o         (drive),
    .steering_o      (steering),
    .drive_mode_o    (drive_mode),
    .line_position_o (line_position),
    .pattern_o       (pattern)
  );

  assign m_axis_tdata = {5'b0, pattern, line_position, drive_mode, steering, drive};

endmodule
`default_nettype wire
